[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the ellipse rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, suspended while reset is asserted.
`define MER_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising clock edge, reset included.
`define MER_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mer_pkg.sv]
// Types and codes shared by the ellipse rasterizer controller, datapath and checker.
package mer_pkg;

  // Values of the command field carried on in_tuser.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RX2,
    ST_RY2,
    ST_RXY,
    ST_INIT,
    ST_CHK,
    ST_EMIT,
    ST_STEP,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_E4,
    ST_E5,
    ST_E6
  } mer_state_t;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RXRX,
    MUL_RYRY,
    MUL_RX2RY,
    MUL_TXTX,
    MUL_TYTY,
    MUL_RY2SQ,
    MUL_RX2SQ,
    MUL_RX2RY2
  } mer_mul_t;

  // Register update performed by the datapath in a cycle.
  typedef enum logic [3:0] {
    WB_NONE,
    WB_RX2,
    WB_RY2,
    WB_INIT,
    WB_SQ,
    WB_DEC_LOAD,
    WB_DEC_ADD4,
    WB_DEC_SUB4,
    WB_EMIT,
    WB_STEP
  } mer_wb_t;

  typedef struct packed {
    logic     start_load;
    mer_mul_t mul;
    mer_wb_t  wb;
    logic     region2;
  } mer_cmd_t;

  typedef struct packed {
    logic out_free;
    logic oy_zero;
    logic grad_lt;
  } mer_status_t;

endpackage

[hdl/mer_dp.sv]
// Datapath of the ellipse rasterizer: walk state, shared multiplier and output register.
module mer_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [COORD_BITS-1:0]             ax,
  input  logic [COORD_BITS-1:0]             ay,
  input  logic [COORD_BITS-1:0]             bx,
  input  logic [COORD_BITS-1:0]             by,
  input  mer_pkg::mer_cmd_t                 cmd,
  input  logic                              out_tready,
  output mer_pkg::mer_status_t              status,
  output logic                              out_tvalid,
  output logic [((8*COORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic                              out_tlast
);

  localparam int C     = COORD_BITS;
  localparam int R     = C - 1;
  localparam int MA    = 2 * R;
  localparam int MB    = 2 * C + 2;
  localparam int DW    = 4 * C;
  localparam int GW    = 3 * C + 4;
  localparam int OUT_W = ((8 * C + 7) / 8) * 8;

  logic [C-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic [R-1:0]     rx_r, rx_nxt, ry_r, ry_nxt;
  logic [C-1:0]     ox_r, ox_nxt, oy_r, oy_nxt;
  logic [GW-1:0]    gx_r, gx_nxt, gy_r, gy_nxt;
  logic [DW-1:0]    dec_r, dec_nxt;
  logic [MA-1:0]    rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic [MB-1:0]    sq_r, sq_nxt;
  logic [DW-1:0]    prod_r, prod_nxt;
  logic             use_gx_r, use_gx_nxt, use_gy_r, use_gy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [8*C-1:0]   out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;

  logic [C:0]       sum_x, sum_y;
  logic [C-1:0]     diff_x, diff_y;
  logic [C:0]       tx;
  logic [C-1:0]     aty;
  logic [MA-1:0]    mul_a;
  logic [MB-1:0]    mul_b;
  logic             dec_neg, dec_pos;
  logic             emit_gx, emit_gy;
  logic [GW-1:0]    two_rx2, two_ry2;
  logic [DW-1:0]    step_term;
  logic [C-1:0]     px_pos, px_neg, py_pos, py_neg;

  assign sum_x  = {1'b0, ax} + {1'b0, bx};
  assign sum_y  = {1'b0, ay} + {1'b0, by};
  assign diff_x = (ax > bx) ? (ax - bx) : (bx - ax);
  assign diff_y = (ay > by) ? (ay - by) : (by - ay);

  // Terms of the region-two seed: (2x+1) and |y-1|, where y-1 is at least -1.
  assign tx  = {ox_r, 1'b1};
  assign aty = (oy_r == '0) ? C'(1) : (oy_r - C'(1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul)
      mer_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      mer_pkg::MUL_RXRX: begin
        mul_a = MA'(rx_r);
        mul_b = MB'(rx_r);
      end
      mer_pkg::MUL_RYRY: begin
        mul_a = MA'(ry_r);
        mul_b = MB'(ry_r);
      end
      mer_pkg::MUL_RX2RY: begin
        mul_a = rx2_r;
        mul_b = MB'(ry_r);
      end
      mer_pkg::MUL_TXTX: begin
        mul_a = MA'(tx);
        mul_b = MB'(tx);
      end
      mer_pkg::MUL_TYTY: begin
        mul_a = MA'(aty);
        mul_b = MB'(aty);
      end
      mer_pkg::MUL_RY2SQ: begin
        mul_a = ry2_r;
        mul_b = sq_r;
      end
      mer_pkg::MUL_RX2SQ: begin
        mul_a = rx2_r;
        mul_b = sq_r;
      end
      mer_pkg::MUL_RX2RY2: begin
        mul_a = rx2_r;
        mul_b = MB'(ry2_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = DW'(mul_a) * DW'(mul_b);

  assign dec_neg = dec_r[DW-1];
  assign dec_pos = !dec_neg && (dec_r != '0);

  // Region one always moves in x and steps y when the decision is not negative;
  // region two always steps y and moves in x when the decision is not positive.
  assign emit_gx = cmd.region2 ? !dec_pos : 1'b1;
  assign emit_gy = cmd.region2 ? 1'b1 : !dec_neg;

  assign two_rx2 = GW'(rx2_r) << 1;
  assign two_ry2 = GW'(ry2_r) << 1;

  assign step_term = (use_gx_r ? DW'($signed(gx_r)) : DW'(0))
                   - (use_gy_r ? DW'($signed(gy_r)) : DW'(0))
                   + DW'(cmd.region2 ? rx2_r : ry2_r);

  assign px_pos = cx_r + ox_r;
  assign px_neg = cx_r - ox_r;
  assign py_pos = cy_r + oy_r;
  assign py_neg = cy_r - oy_r;

  always_comb begin
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    dec_nxt       = dec_r;
    rx2_nxt       = rx2_r;
    ry2_nxt       = ry2_r;
    sq_nxt        = sq_r;
    use_gx_nxt    = use_gx_r;
    use_gy_nxt    = use_gy_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (cmd.start_load) begin
      cx_nxt = sum_x[C:1];
      cy_nxt = sum_y[C:1];
      rx_nxt = diff_x[C-1:1];
      ry_nxt = diff_y[C-1:1];
      ox_nxt = '0;
      oy_nxt = C'(diff_y[C-1:1]);
      gx_nxt = '0;
    end

    case (cmd.wb)
      mer_pkg::WB_NONE: begin
      end
      mer_pkg::WB_RX2: begin
        rx2_nxt = prod_r[MA-1:0];
      end
      mer_pkg::WB_RY2: begin
        ry2_nxt = prod_r[MA-1:0];
      end
      mer_pkg::WB_INIT: begin
        gy_nxt  = {prod_r[GW-2:0], 1'b0};
        dec_nxt = (DW'(ry2_r) << 2) - (prod_r << 2) + DW'(rx2_r);
      end
      mer_pkg::WB_SQ: begin
        sq_nxt = prod_r[MB-1:0];
      end
      mer_pkg::WB_DEC_LOAD: begin
        dec_nxt = prod_r;
      end
      mer_pkg::WB_DEC_ADD4: begin
        dec_nxt = dec_r + (prod_r << 2);
      end
      mer_pkg::WB_DEC_SUB4: begin
        dec_nxt = dec_r - (prod_r << 2);
      end
      mer_pkg::WB_EMIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {py_neg, px_neg, py_neg, px_pos, py_pos, px_neg, py_pos, px_pos};
        out_last_nxt  = cmd.region2 && (oy_r == '0);
        use_gx_nxt    = emit_gx;
        use_gy_nxt    = emit_gy;
        if (emit_gx) begin
          gx_nxt = gx_r + two_ry2;
        end
        if (emit_gy) begin
          gy_nxt = gy_r - two_rx2;
        end
        if (!cmd.region2 || emit_gx) begin
          ox_nxt = ox_r + C'(1);
        end
        if (cmd.region2 || emit_gy) begin
          oy_nxt = oy_r - C'(1);
        end
      end
      mer_pkg::WB_STEP: begin
        dec_nxt = dec_r + (step_term << 2);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    dec_r      <= dec_nxt;
    rx2_r      <= rx2_nxt;
    ry2_r      <= ry2_nxt;
    sq_r       <= sq_nxt;
    prod_r     <= prod_nxt;
    use_gx_r   <= use_gx_nxt;
    use_gy_r   <= use_gy_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign status.oy_zero  = (oy_r == '0);
  assign status.grad_lt  = $signed(gx_r) < $signed(gy_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule

[hdl/mer_ctrl.sv]
// Controller of the ellipse rasterizer: sequences start, point steps and region-two entry.
module mer_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tuser,
  input  mer_pkg::mer_status_t status,
  output logic                 in_tready,
  output mer_pkg::mer_cmd_t    cmd
);

  mer_pkg::mer_state_t state_r, state_nxt;
  logic                active_r, active_nxt;
  logic                region2_r, region2_nxt;

  always_comb begin
    state_nxt   = state_r;
    active_nxt  = active_r;
    region2_nxt = region2_r;
    case (state_r)
      mer_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == mer_pkg::CMD_START) begin
            state_nxt   = mer_pkg::ST_RX2;
            active_nxt  = 1'b1;
            region2_nxt = 1'b0;
          end else if (active_r) begin
            state_nxt = mer_pkg::ST_EMIT;
          end
        end
      end
      mer_pkg::ST_RX2:  state_nxt = mer_pkg::ST_RY2;
      mer_pkg::ST_RY2:  state_nxt = mer_pkg::ST_RXY;
      mer_pkg::ST_RXY:  state_nxt = mer_pkg::ST_INIT;
      mer_pkg::ST_INIT: state_nxt = mer_pkg::ST_CHK;
      mer_pkg::ST_CHK: begin
        state_nxt = status.grad_lt ? mer_pkg::ST_IDLE : mer_pkg::ST_E1;
      end
      mer_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = mer_pkg::ST_STEP;
          if (region2_r && status.oy_zero) begin
            active_nxt = 1'b0;
          end
        end
      end
      mer_pkg::ST_STEP: begin
        // The gradients were updated in the emit cycle, so the region test sees them here.
        if (!region2_r && !status.grad_lt) begin
          state_nxt = mer_pkg::ST_E1;
        end else begin
          state_nxt = mer_pkg::ST_IDLE;
        end
      end
      mer_pkg::ST_E1: state_nxt = mer_pkg::ST_E2;
      mer_pkg::ST_E2: state_nxt = mer_pkg::ST_E3;
      mer_pkg::ST_E3: state_nxt = mer_pkg::ST_E4;
      mer_pkg::ST_E4: state_nxt = mer_pkg::ST_E5;
      mer_pkg::ST_E5: state_nxt = mer_pkg::ST_E6;
      mer_pkg::ST_E6: begin
        state_nxt   = mer_pkg::ST_IDLE;
        region2_nxt = 1'b1;
      end
      default: state_nxt = mer_pkg::ST_IDLE;
    endcase
  end

  // Each multiply is issued in the state before the one whose update consumes the registered product.
  always_comb begin
    in_tready      = 1'b0;
    cmd.start_load = 1'b0;
    cmd.mul        = mer_pkg::MUL_NONE;
    cmd.wb         = mer_pkg::WB_NONE;
    cmd.region2    = region2_r;
    case (state_r)
      mer_pkg::ST_IDLE: begin
        in_tready      = 1'b1;
        cmd.start_load = in_tvalid && (in_tuser == mer_pkg::CMD_START);
      end
      mer_pkg::ST_RX2: begin
        cmd.mul = mer_pkg::MUL_RXRX;
      end
      mer_pkg::ST_RY2: begin
        cmd.mul = mer_pkg::MUL_RYRY;
        cmd.wb  = mer_pkg::WB_RX2;
      end
      mer_pkg::ST_RXY: begin
        cmd.mul = mer_pkg::MUL_RX2RY;
        cmd.wb  = mer_pkg::WB_RY2;
      end
      mer_pkg::ST_INIT: begin
        cmd.wb = mer_pkg::WB_INIT;
      end
      mer_pkg::ST_CHK: begin
      end
      mer_pkg::ST_EMIT: begin
        cmd.wb = status.out_free ? mer_pkg::WB_EMIT : mer_pkg::WB_NONE;
      end
      mer_pkg::ST_STEP: begin
        cmd.wb = mer_pkg::WB_STEP;
      end
      mer_pkg::ST_E1: begin
        cmd.mul = mer_pkg::MUL_TXTX;
      end
      mer_pkg::ST_E2: begin
        cmd.mul = mer_pkg::MUL_TYTY;
        cmd.wb  = mer_pkg::WB_SQ;
      end
      mer_pkg::ST_E3: begin
        cmd.mul = mer_pkg::MUL_RY2SQ;
        cmd.wb  = mer_pkg::WB_SQ;
      end
      mer_pkg::ST_E4: begin
        cmd.mul = mer_pkg::MUL_RX2SQ;
        cmd.wb  = mer_pkg::WB_DEC_LOAD;
      end
      mer_pkg::ST_E5: begin
        cmd.mul = mer_pkg::MUL_RX2RY2;
        cmd.wb  = mer_pkg::WB_DEC_ADD4;
      end
      mer_pkg::ST_E6: begin
        cmd.wb = mer_pkg::WB_DEC_SUB4;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mer_pkg::ST_IDLE;
      active_r  <= 1'b0;
      region2_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      active_r  <= active_nxt;
      region2_r <= region2_nxt;
    end
  end

endmodule

[hdl/midpoint_ellipse_rasterizer_top.sv]
// An accepted advance moves the controller to the emit state, which loads its point into
// the output register once that register is free; an advance that ends region one then
// also runs the region-two seed on the shared multiplier. A start word runs the setup
// states, plus the seed when the walk begins in region two. Words are taken only in idle.
// Synchronous active-low reset clears the controller, the walk flags and the output valid.
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // corner_ax, corner_ay, corner_bx, corner_by from the lowest bit up
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // command
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y from the lowest bit up
  output logic [((8*COORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic                              out_tlast
);

  localparam int C = COORD_BITS;

  mer_pkg::mer_cmd_t    cmd;
  mer_pkg::mer_status_t status;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  mer_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ax         (in_tdata[C-1:0]),
    .ay         (in_tdata[2*C-1:C]),
    .bx         (in_tdata[3*C-1:2*C]),
    .by         (in_tdata[4*C-1:3*C]),
    .cmd        (cmd),
    .out_tready (out_tready),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/mer_checker.sv]
// Port-level assertions for the ellipse rasterizer and the bind that attaches them.
`include "assert_macros.svh"

module mer_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((8*COORD_BITS+7)/8)*8-1:0] out_tdata,
  input logic                              out_tlast
);

  logic in_word;
  logic in_start;
  logic out_stall;
  assign in_word   = in_tvalid && in_tready;
  assign in_start  = in_word && (in_tuser == mer_pkg::CMD_START);
  assign out_stall = out_tvalid && !out_tready;

  // A held result word stays offered.
  `MER_ASSERT(a_out_hold, out_stall |=> out_tvalid, "out word dropped")

  // A held result word keeps its payload.
  `MER_ASSERT(a_out_stable, out_stall |=> $stable(out_tdata) && $stable(out_tlast), "out word changed")

  // Reset empties the output register.
  `MER_ASSERT_NORST(a_rst_empty, !rst_n |=> !out_tvalid, "out valid after reset")

  // A start word never yields a point of its own.
  `MER_ASSERT(a_start_silent, in_start && !out_tvalid |=> !out_tvalid, "point after start")

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker #(.COORD_BITS(COORD_BITS)) u_mer_checker (.*);
